// ===== sv/smd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_pkg: types and constants of the scaled multiply-divide block
// request and response word layouts and the fixed widths of the datapath
// ----------------------------------------------------------------------------
package smd_pkg;

   localparam int DataWidth    = 32;
   localparam int FactorWidth  = 32;
   localparam int DivisorWidth = 20;
   localparam int ShiftWidth   = 5;
   localparam int ProductWidth = 2 * FactorWidth;
   localparam int CountWidth   = $clog2(ProductWidth + (1 << ShiftWidth));

   typedef struct packed {
      logic [FactorWidth-1:0]  multiplicand;
      logic [FactorWidth-1:0]  multiplier;
      logic [DivisorWidth-1:0] divisor;
      logic [ShiftWidth-1:0]   scale_shift;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] quotient;
      logic                 divide_error;
      logic                 overflow;
   } rsp_type;

endpackage

// ===== sv/scaled_multiply_divide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_multiply_divide: bit-serial floor(a * b * 2^s / d)
//
// A request word is taken at a rising edge where start is high and busy is
// low. The block then forms the 64-bit product by shift-and-add, one
// multiplier bit per cycle, and divides the product followed by s zero
// bits by the divisor with a restoring divider, one quotient bit per
// cycle. rsp_valid is high for one cycle with the response word: the
// low 32 bits of the quotient, divide_error for a zero divisor (quotient
// 0) and overflow when the true quotient needs more than 32 bits.
// The strobe follows the multiply loop (StMul) and the divide loop (StDiv);
// a zero divisor skips both and answers the cycle after accept. busy drops
// in the strobe cycle, so a new request may be taken at the edge that
// ends it: one request in flight at a time. The receiver cannot stall:
// each response is shown exactly once.
// Synchronous reset returns the sequencer to idle and clears the strobe;
// the datapath registers are not reset.
// ----------------------------------------------------------------------------
module scaled_multiply_divide (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  smd_pkg::req_type req,
   output logic            rsp_valid,
   output smd_pkg::rsp_type rsp
);
   import smd_pkg::*;

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StMul  = 2'd1;
   localparam logic [1:0] StDiv  = 2'd2;

   localparam logic [CountWidth-1:0] MulLast = CountWidth'(FactorWidth - 1);
   localparam logic [CountWidth-1:0] DivBase = CountWidth'(ProductWidth - 1);

   logic [1:0]              state_ff, state_in;
   logic [CountWidth-1:0]   cnt_ff, cnt_in;
   logic [FactorWidth-1:0]  a_ff, a_in;
   logic [ProductWidth-1:0] acc_ff, acc_in;
   logic [DivisorWidth-1:0] d_ff, d_in;
   logic [ShiftWidth-1:0]   shift_ff, shift_in;
   logic [DivisorWidth-1:0] rem_ff, rem_in;
   logic [DataWidth-1:0]    q_ff, q_in;
   logic                    ovf_ff, ovf_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [FactorWidth:0]    mul_sum;
   logic [DivisorWidth:0]   trial;
   logic [DivisorWidth+1:0] diff;
   logic                    ge;
   logic [CountWidth-1:0]   div_last;

   always_comb begin
      mul_sum  = {1'b0, acc_ff[ProductWidth-1:FactorWidth]}
               + {1'b0, (acc_ff[0] ? a_ff : {FactorWidth{1'b0}})};
      trial    = {rem_ff, acc_ff[ProductWidth-1]};
      diff     = {1'b0, trial} - {2'b00, d_ff};
      ge       = !diff[DivisorWidth+1];
      div_last = DivBase + CountWidth'(shift_ff);
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      a_in         = a_ff;
      acc_in       = acc_ff;
      d_in         = d_ff;
      shift_in     = shift_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         StIdle: begin
            if (start) begin
               a_in     = req.multiplicand;
               acc_in   = {{FactorWidth{1'b0}}, req.multiplier};
               d_in     = req.divisor;
               shift_in = req.scale_shift;
               rem_in   = '0;
               q_in     = '0;
               ovf_in   = 1'b0;
               cnt_in   = '0;
               if (req.divisor == '0) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.quotient     = '0;
                  rsp_in.divide_error = 1'b1;
                  rsp_in.overflow     = 1'b0;
               end else begin
                  state_in = StMul;
               end
            end
         end
         StMul: begin
            // add-and-shift with the multiplier held in the low half
            acc_in = {mul_sum, acc_ff[FactorWidth-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == MulLast) begin
               state_in = StDiv;
               cnt_in   = '0;
            end
         end
         StDiv: begin
            // restoring divide, dividend bits from the product msb first
            acc_in = {acc_ff[ProductWidth-2:0], 1'b0};
            rem_in = ge ? diff[DivisorWidth-1:0] : trial[DivisorWidth-1:0];
            q_in   = {q_ff[DataWidth-2:0], ge};
            ovf_in = ovf_ff | q_ff[DataWidth-1];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == div_last) begin
               state_in            = StIdle;
               rsp_valid_in        = 1'b1;
               rsp_in.quotient     = q_in;
               rsp_in.divide_error = 1'b0;
               rsp_in.overflow     = ovf_in;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      a_ff     <= a_in;
      acc_ff   <= acc_in;
      d_ff     <= d_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      ovf_ff   <= ovf_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != StIdle);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
